FILE: sv/crle_pkg.sv
package crle_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         run_value;
    logic [12:0]        run_count;
    logic [12:0]        run_offset;
    logic signed [31:0] chunk_x;
    logic signed [31:0] chunk_y;
    logic signed [31:0] chunk_z;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RLE   = 2'd1;
  localparam logic [1:0] ST_CRC   = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  localparam logic [4:0]  HEADER_LEN = 5'd20;
  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES   = 32'hFFFFFFFF;

  // Controller to datapath.
  typedef struct packed {
    logic absorb;      // take the input byte into the parser state
    logic crc_start;   // load the CRC repeat counter for the pending run
    logic crc_step;    // fold one byte of the run into the CRC
    logic emit_run;    // present the run result
    logic emit_stat;   // present the chunk status result
    logic emit_trunc;  // present a truncated status result
    logic stat_last;   // the result emitted now is the last of the beat
    logic clear;       // clear per-chunk state
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic run_ok;      // the byte completes a triplet that yields a run
    logic run_nonzero; // that run has a nonzero count
    logic pay_end;     // the byte ends the record
    logic eof_trunc;   // end of file comes mid-record
    logic crc_done;    // repeat counter reaches its last byte
  } dp_stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      v = (v >> 1) ^ (CRC_POLY & {32{v[0]}});
    end
    return v;
  endfunction

endpackage

FILE: sv/chunk_record_rle_crc_decoder.sv
// Channel | Ports                                 | Payload
// input   | in_valid, in_stall, in_item           | data_byte, end_of_file
// result  | out_valid, out_stall, out_item        | run or status record
//
// A header byte or a byte inside a triplet is absorbed alone, followed by any status beat.
// A byte that closes a triplet with a run presents the run until out_stall is low;
// then, for a nonzero count, the CRC unit folds one decoded byte per cycle.
// Reset is synchronous and returns the parser to the start of a header.
// Input is stalled whenever a result is presented or the CRC loop runs.
module chunk_record_rle_crc_decoder #(
  parameter int CHUNK_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  crle_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output crle_pkg::out_item_t out_item
);

  crle_pkg::dp_cmd_t  cmd;
  crle_pkg::dp_stat_t stat;

  crle_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .eof(in_item.end_of_file), .out_valid(out_valid), .out_stall(out_stall),
    .stat(stat), .cmd(cmd)
  );

  crle_datapath #(.CHUNK_BYTES(CHUNK_BYTES)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd), .stat(stat),
    .res(out_item)
  );

endmodule

FILE: sv/crle_datapath.sv
module crle_datapath #(
  parameter int CHUNK_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  crle_pkg::in_item_t  in_item,
  input  crle_pkg::dp_cmd_t   cmd,
  output crle_pkg::dp_stat_t  stat,
  output crle_pkg::out_item_t res
);

  localparam int TW = $clog2(CHUNK_BYTES + 1) + 1;
  localparam int SW = ((TW > 16) ? TW : 16) + 1;

  logic        phase_r, phase_nxt;
  logic [4:0]  hidx_r, hidx_nxt;
  logic [31:0] cx_r, cy_r, cz_r, plen_r, ecrc_r;
  logic [31:0] cx_nxt, cy_nxt, cz_nxt, plen_nxt, ecrc_nxt;
  logic [1:0]  tidx_r, tidx_nxt;
  logic [15:0] pend_r, pend_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        fail_r, fail_nxt;
  logic [15:0] rep_r, rep_nxt;
  logic [7:0]  rval_r, rval_nxt;
  logic [TW-1:0] roff_r, roff_nxt;
  logic [15:0] rcnt_r, rcnt_nxt;
  logic [1:0]  fstat;
  logic [SW-1:0] sum;

  assign sum = SW'(total_r) + SW'(pend_r);

  always_comb begin
    if (fail_r || tidx_r != 2'd0 || total_r != TW'(CHUNK_BYTES)) begin
      fstat = crle_pkg::ST_RLE;
    end else if ((crc_r ^ crle_pkg::CRC_ONES) != ecrc_r) begin
      fstat = crle_pkg::ST_CRC;
    end else begin
      fstat = crle_pkg::ST_OK;
    end
  end

  // The length word is complete before the last header byte arrives.
  always_comb begin
    stat.run_ok = phase_r && tidx_r == 2'd2 && !fail_r && sum <= SW'(CHUNK_BYTES);
    stat.run_nonzero = pend_r != 16'd0;
    stat.pay_end = phase_r ? (plen_r == 32'd1)
                           : (hidx_r == 5'd19 && plen_r == 32'd0);
    stat.eof_trunc = in_item.end_of_file && !stat.pay_end;
    stat.crc_done = rep_r == 16'd1;
  end

  always_comb begin
    logic [4:0] idx;
    logic [7:0] b;
    phase_nxt = phase_r; hidx_nxt = hidx_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cz_nxt = cz_r; plen_nxt = plen_r; ecrc_nxt = ecrc_r;
    tidx_nxt = tidx_r; pend_nxt = pend_r; total_nxt = total_r; crc_nxt = crc_r;
    fail_nxt = fail_r; rep_nxt = rep_r; rval_nxt = rval_r; roff_nxt = roff_r;
    rcnt_nxt = rcnt_r;
    b = in_item.data_byte;
    idx = (hidx_r >= crle_pkg::HEADER_LEN) ? 5'd0 : hidx_r;
    if (cmd.absorb) begin
      if (!phase_r) begin
        if (idx == 5'd0) begin
          cx_nxt = '0; cy_nxt = '0; cz_nxt = '0; plen_nxt = '0; ecrc_nxt = '0;
        end
        unique case (idx[4:2])
          3'd0: cx_nxt[idx[1:0]*8 +: 8] = b;
          3'd1: cy_nxt[idx[1:0]*8 +: 8] = b;
          3'd2: cz_nxt[idx[1:0]*8 +: 8] = b;
          3'd3: plen_nxt[idx[1:0]*8 +: 8] = b;
          default: ecrc_nxt[idx[1:0]*8 +: 8] = b;
        endcase
        if (idx == crle_pkg::HEADER_LEN - 5'd1) begin
          hidx_nxt = 5'd0;
          phase_nxt = 1'b1;
        end else begin
          hidx_nxt = idx + 5'd1;
        end
      end else begin
        plen_nxt = plen_r - 32'd1;
        unique case (tidx_r)
          2'd0: begin pend_nxt = {8'd0, b}; tidx_nxt = 2'd1; end
          2'd1: begin pend_nxt = {b, pend_r[7:0]}; tidx_nxt = 2'd2; end
          default: begin
            tidx_nxt = 2'd0;
            if (!fail_r) begin
              if (sum > SW'(CHUNK_BYTES)) begin
                fail_nxt = 1'b1;
              end else begin
                rval_nxt = b;
                rcnt_nxt = pend_r;
                roff_nxt = total_r;
                total_nxt = sum[TW-1:0];
              end
            end
          end
        endcase
      end
    end
    if (cmd.crc_start) rep_nxt = rcnt_r;
    if (cmd.crc_step) begin
      crc_nxt = crle_pkg::crc_byte(crc_r, rval_r);
      rep_nxt = rep_r - 16'd1;
    end
    if (cmd.clear) begin
      phase_nxt = 1'b0; hidx_nxt = '0; plen_nxt = '0; tidx_nxt = '0; pend_nxt = '0;
      total_nxt = '0; crc_nxt = crle_pkg::CRC_ONES; fail_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0; hidx_r <= '0; cx_r <= '0; cy_r <= '0; cz_r <= '0;
      plen_r <= '0; ecrc_r <= '0; tidx_r <= '0; pend_r <= '0; total_r <= '0;
      crc_r <= crle_pkg::CRC_ONES; fail_r <= 1'b0; rep_r <= '0;
      rval_r <= '0; roff_r <= '0; rcnt_r <= '0;
    end else begin
      phase_r <= phase_nxt; hidx_r <= hidx_nxt; cx_r <= cx_nxt; cy_r <= cy_nxt;
      cz_r <= cz_nxt; plen_r <= plen_nxt; ecrc_r <= ecrc_nxt; tidx_r <= tidx_nxt;
      pend_r <= pend_nxt; total_r <= total_nxt; crc_r <= crc_nxt; fail_r <= fail_nxt;
      rep_r <= rep_nxt;
      rval_r <= rval_nxt; roff_r <= roff_nxt; rcnt_r <= rcnt_nxt;
    end
  end

  always_comb begin
    res = '0;
    res.chunk_x = cx_r; res.chunk_y = cy_r; res.chunk_z = cz_r;
    res.last = cmd.stat_last;
    if (cmd.emit_run) begin
      res.run_value = rval_r;
      res.run_count = rcnt_r[12:0];
      res.run_offset = 13'(roff_r);
    end else if (cmd.emit_stat || cmd.emit_trunc) begin
      res.kind = 1'b1;
      res.status = cmd.emit_trunc ? crle_pkg::ST_TRUNC : fstat;
    end
  end

endmodule

FILE: sv/crle_ctrl.sv
module crle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               eof,
  output logic               out_valid,
  input  logic               out_stall,
  input  crle_pkg::dp_stat_t stat,
  output crle_pkg::dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CRC   = 5'b00010,
    S_RUN   = 5'b00100,
    S_STAT  = 5'b01000,
    S_TRUNC = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   run_nz_r, run_nz_nxt;
  logic   pend_stat_r, pend_stat_nxt;
  logic   pend_trunc_r, pend_trunc_nxt;
  logic   go;

  assign in_stall = state_r != S_IDLE;
  assign go = in_valid && state_r == S_IDLE;
  assign out_valid = state_r == S_RUN || state_r == S_STAT || state_r == S_TRUNC;

  // Status outputs use the values latched when the beat was absorbed.
  always_comb begin
    state_t after_run;
    cmd = '0;
    state_nxt = state_r;
    run_nz_nxt = run_nz_r;
    pend_stat_nxt = pend_stat_r;
    pend_trunc_nxt = pend_trunc_r;
    after_run = pend_stat_r ? S_STAT : (pend_trunc_r ? S_TRUNC : S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (go) begin
          cmd.absorb = 1'b1;
          run_nz_nxt = stat.run_nonzero;
          pend_stat_nxt = stat.pay_end;
          pend_trunc_nxt = eof && stat.eof_trunc;
          if (stat.run_ok) begin
            state_nxt = S_RUN;
          end else if (stat.pay_end) begin
            state_nxt = S_STAT;
          end else if (eof && stat.eof_trunc) begin
            state_nxt = S_TRUNC;
          end
        end
      end
      S_RUN: begin
        cmd.emit_run = 1'b1;
        cmd.stat_last = !pend_stat_r && !pend_trunc_r;
        if (!out_stall) begin
          if (run_nz_r) begin
            cmd.crc_start = 1'b1;
            state_nxt = S_CRC;
          end else begin
            state_nxt = after_run;
          end
        end
      end
      S_CRC: begin
        cmd.crc_step = 1'b1;
        if (stat.crc_done) state_nxt = after_run;
      end
      S_STAT: begin
        cmd.emit_stat = 1'b1;
        cmd.stat_last = 1'b1;
        if (!out_stall) begin
          cmd.clear = 1'b1;
          pend_stat_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      S_TRUNC: begin
        cmd.emit_trunc = 1'b1;
        cmd.stat_last = 1'b1;
        if (!out_stall) begin
          cmd.clear = 1'b1;
          pend_trunc_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      run_nz_r <= 1'b0;
      pend_stat_r <= 1'b0;
      pend_trunc_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      run_nz_r <= run_nz_nxt;
      pend_stat_r <= pend_stat_nxt;
      pend_trunc_r <= pend_trunc_nxt;
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while a result waits");
  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(state_r))
    else $error("result dropped under stall");
  a_crc_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CRC |-> $past(state_r) == S_RUN || $past(state_r) == S_CRC)
    else $error("CRC loop entered without a run");
  a_stat_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_stat_r && pend_trunc_r)) else $error("status and truncation both pending");

endmodule
